/* hdl/cic_pkg.sv */
`timescale 1ns / 1ps

package cic_pkg;

    localparam int NUM_KINDS   = 8;
    localparam int CNT_W       = 10;
    localparam int AMT_W       = 16;
    localparam int REG_IDX_W   = 2;
    // fixed-point scale of the per-cell reciprocal; must be at least AMT_W
    localparam int RECIP_SHIFT = 24;

    localparam int unsigned DENOM_VALUE [NUM_KINDS] = '{5, 10, 20, 50, 100, 200, 500, 1000};

    localparam logic [REG_IDX_W-1:0] REG_MAX_COUNT     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_COUNT = 2'd1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHANGE = 2'd2,
        OP_FILL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ADD_OVER     = 2'd1,
        ST_REMOVE_UNDER = 2'd2,
        ST_NOT_EXACT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CC_NONE,
        CC_ADD,
        CC_SUB,
        CC_TAKE,
        CC_FILL
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_WALK,
        S_DONE
    } fsm_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [CNT_W-1:0]   max_cnt;
        logic [CNT_W-1:0]   dflt_cnt;
    } cell_ctrl_t;

    typedef struct packed {
        logic add_fail;
        logic sub_fail;
    } cell_flags_t;

endpackage

/* hdl/cic_cell.sv */
`timescale 1ns / 1ps

// One denomination: holds its count, checks add/remove, and takes its share of
// a change amount in two stages (reciprocal multiply, then correct and clamp).
module cic_cell #(
    parameter int unsigned DENOM = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cic_pkg::cell_ctrl_t       ctrl,
    input  logic [cic_pkg::CNT_W-1:0] qty,
    input  logic                      tok_in,
    input  logic [cic_pkg::AMT_W-1:0] rem_in,
    output logic                      tok_out,
    output logic [cic_pkg::AMT_W-1:0] rem_out,
    output logic [cic_pkg::CNT_W-1:0] give,
    output cic_pkg::cell_flags_t      flags
);
    import cic_pkg::*;

    localparam int unsigned RECIP  = (1 << RECIP_SHIFT) / DENOM;
    localparam int          RECIP_W = $clog2(RECIP + 1);
    localparam int          PROD_W  = AMT_W + RECIP_W;
    localparam int          CD_W    = CNT_W + $clog2(DENOM + 1);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              va_reg;
    logic [AMT_W-1:0]  rem_a_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CD_W-1:0]   cd_reg;
    logic              tok_reg;
    logic [AMT_W-1:0]  rem_out_reg;
    logic [CNT_W-1:0]  give_reg;

    logic [CNT_W:0]    sum;
    logic [AMT_W-1:0]  q0, qd, r0, q, r, rem_b;
    logic              fix;
    logic [CNT_W-1:0]  k;

    // stage A: quotient estimate and full-stock value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else begin
            va_reg <= tok_in;
        end
        if (tok_in) begin
            rem_a_reg <= rem_in;
            prod_reg  <= PROD_W'(rem_in) * PROD_W'(RECIP);
            cd_reg    <= CD_W'(count_reg) * CD_W'(DENOM);
        end
    end

    // stage B: estimate is exact or one low
    always_comb begin
        q0  = AMT_W'(prod_reg >> RECIP_SHIFT);
        qd  = AMT_W'(q0 * AMT_W'(DENOM));
        r0  = rem_a_reg - qd;
        fix = (r0 >= AMT_W'(DENOM));
        q   = q0 + AMT_W'(fix);
        r   = fix ? (r0 - AMT_W'(DENOM)) : r0;
        if (q > AMT_W'(count_reg)) begin
            k     = count_reg;
            rem_b = rem_a_reg - AMT_W'(cd_reg);
        end else begin
            k     = CNT_W'(q);
            rem_b = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= va_reg;
        end
        if (va_reg) begin
            give_reg    <= k;
            rem_out_reg <= rem_b;
        end
    end

    assign sum            = {1'b0, count_reg} + {1'b0, qty};
    assign flags.add_fail = (sum > {1'b0, ctrl.max_cnt});
    assign flags.sub_fail = (qty > count_reg);

    always_comb begin
        case (ctrl.cmd)
            CC_ADD:  count_next = sum[CNT_W-1:0];
            CC_SUB:  count_next = count_reg - qty;
            CC_TAKE: count_next = count_reg - give_reg;
            CC_FILL: count_next = ctrl.dflt_cnt;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign tok_out = tok_reg;
    assign rem_out = rem_out_reg;
    assign give    = give_reg;

endmodule

/* hdl/coin_inventory_change_maker.sv */
`timescale 1ns / 1ps

// Coin inventory with greedy change making. Eight cells, one per denomination
// (5 to 1000 cents), each keep a 10-bit stock count. Add and remove check all
// eight cells at once and commit only if none would leave the range
// [0, max_coin_count]; fill loads the default count everywhere. Make change
// sends a remainder token down the cell chain from the 1000c cell to the 5c
// cell; each cell takes min(rem / denom, stock) through a reciprocal multiply
// stage and then a correct-and-clamp stage, both registered. Counts move only
// when the remainder reaches zero. Add, remove and fill go through the apply
// state, change through the walk state until the token leaves the 5c cell.
// A finished beat waits in the done state until the output register is free.
// The result sits in an output register, so the next beat is accepted while
// it waits. One result beat per input beat; change counts are zero unless a
// change succeeds. Config writes (index 0 max count, 1 default count) are
// always accepted and are meant for idle periods only.
module coin_inventory_change_maker (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cic_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [cic_pkg::CNT_W-1:0]     cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [cic_pkg::AMT_W-1:0]     s_amount_cents,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_5c,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_10c,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_20c,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_50c,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_100c,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_200c,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_500c,
    input  logic [cic_pkg::CNT_W-1:0]     s_qty_1000c,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [cic_pkg::CNT_W-1:0]     m_change_5c,
    output logic [cic_pkg::CNT_W-1:0]     m_change_10c,
    output logic [cic_pkg::CNT_W-1:0]     m_change_20c,
    output logic [cic_pkg::CNT_W-1:0]     m_change_50c,
    output logic [cic_pkg::CNT_W-1:0]     m_change_100c,
    output logic [cic_pkg::CNT_W-1:0]     m_change_200c,
    output logic [cic_pkg::CNT_W-1:0]     m_change_500c,
    output logic [cic_pkg::CNT_W-1:0]     m_change_1000c
);
    import cic_pkg::*;

    // control and config
    fsm_t             state_reg, state_next;
    op_t              op_reg;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] max_reg;
    logic [CNT_W-1:0] dflt_reg;

    // operand and result storage
    logic [CNT_W-1:0] qty_in   [NUM_KINDS];
    logic [CNT_W-1:0] qty_reg  [NUM_KINDS];
    logic [CNT_W-1:0] give     [NUM_KINDS];
    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [CNT_W-1:0] m_change_reg [NUM_KINDS];

    // cell chain: index NUM_KINDS is the head (feeds the 1000c cell)
    logic [NUM_KINDS:0] tok_chain;
    logic [AMT_W-1:0]   rem_chain [NUM_KINDS+1];
    cell_ctrl_t         ctrl;
    cell_cmd_t          cmd;
    cell_flags_t        flags [NUM_KINDS];
    logic               any_add_fail, any_sub_fail;

    logic accept, tok_start, out_free, out_load, exact;

    assign qty_in[0] = s_qty_5c;
    assign qty_in[1] = s_qty_10c;
    assign qty_in[2] = s_qty_20c;
    assign qty_in[3] = s_qty_50c;
    assign qty_in[4] = s_qty_100c;
    assign qty_in[5] = s_qty_200c;
    assign qty_in[6] = s_qty_500c;
    assign qty_in[7] = s_qty_1000c;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign exact    = (rem_chain[0] == '0);

    // chain head takes the amount straight off the input beat
    assign tok_chain[NUM_KINDS] = tok_start;
    assign rem_chain[NUM_KINDS] = s_amount_cents;

    assign ctrl.cmd      = cmd;
    assign ctrl.max_cnt  = max_reg;
    assign ctrl.dflt_cnt = dflt_reg;

    generate
        for (genvar i = 0; i < NUM_KINDS; i++) begin : g_cell
            cic_cell #(
                .DENOM (DENOM_VALUE[i])
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .qty     (qty_reg[i]),
                .tok_in  (tok_chain[i+1]),
                .rem_in  (rem_chain[i+1]),
                .tok_out (tok_chain[i]),
                .rem_out (rem_chain[i]),
                .give    (give[i]),
                .flags   (flags[i])
            );
        end
    endgenerate

    always_comb begin
        any_add_fail = 1'b0;
        any_sub_fail = 1'b0;
        for (int i = 0; i < NUM_KINDS; i++) begin
            any_add_fail = any_add_fail | flags[i].add_fail;
            any_sub_fail = any_sub_fail | flags[i].sub_fail;
        end
    end

    // sequencer: next state and strobes
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        s_ready     = 1'b0;
        tok_start   = 1'b0;
        cmd         = CC_NONE;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (op_t'(s_operation) == OP_CHANGE) begin
                        tok_start  = 1'b1;
                        state_next = S_WALK;
                    end else begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_APPLY: begin
                case (op_reg)
                    OP_ADD: begin
                        status_next = any_add_fail ? ST_ADD_OVER : ST_OK;
                        cmd         = any_add_fail ? CC_NONE : CC_ADD;
                    end
                    OP_REMOVE: begin
                        status_next = any_sub_fail ? ST_REMOVE_UNDER : ST_OK;
                        cmd         = any_sub_fail ? CC_NONE : CC_SUB;
                    end
                    default: begin
                        status_next = ST_OK;
                        cmd         = CC_FILL;
                    end
                endcase
                state_next = S_DONE;
            end
            S_WALK: begin
                // token leaving the 5c cell closes the walk
                if (tok_chain[0]) begin
                    status_next = exact ? ST_OK : ST_NOT_EXACT;
                    cmd         = exact ? CC_TAKE : CC_NONE;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op_t'(s_operation);
            for (int i = 0; i < NUM_KINDS; i++) begin
                qty_reg[i] <= qty_in[i];
            end
        end
    end

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg  <= CNT_W'(1023);
            dflt_reg <= CNT_W'(20);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MAX_COUNT:     max_reg  <= cfg_data;
                REG_DEFAULT_COUNT: dflt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_status_reg <= status_reg;
            for (int i = 0; i < NUM_KINDS; i++) begin
                m_change_reg[i] <= (op_reg == OP_CHANGE && status_reg == ST_OK) ?
                                   give[i] : '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_change_5c    = m_change_reg[0];
    assign m_change_10c   = m_change_reg[1];
    assign m_change_20c   = m_change_reg[2];
    assign m_change_50c   = m_change_reg[3];
    assign m_change_100c  = m_change_reg[4];
    assign m_change_200c  = m_change_reg[5];
    assign m_change_500c  = m_change_reg[6];
    assign m_change_1000c = m_change_reg[7];

    // at most one change token is ever in flight along the chain
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_chain) <= 1)
        else $error("more than one token in the cell chain");

    // a token only leaves the chain while the sequencer is walking
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok_chain[0] |-> state_reg == S_WALK)
        else $error("chain token outside a change walk");

    // a new result beat is only produced out of the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result beat without a finished operation");

    // failed operations never report change
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |->
        (m_change_5c == '0 && m_change_10c == '0 && m_change_20c == '0 &&
         m_change_50c == '0 && m_change_100c == '0 && m_change_200c == '0 &&
         m_change_500c == '0 && m_change_1000c == '0))
        else $error("change counts on a failed beat");

endmodule
